// File: sv/slvt_pkg.sv
// Shared types, op codes, constants and trig tables for the skeletal vertex transform.
package slvt_pkg;

  localparam int unsigned MAX_GROUP_VERTS = 65535;
  localparam int unsigned TRIG_ENTRIES    = 2048;
  localparam int unsigned ROM_DEPTH       = TRIG_ENTRIES / 8;
  localparam int unsigned QUARTER_DEPTH   = ROM_DEPTH / 4;
  localparam int unsigned ROM_AW          = $clog2(ROM_DEPTH);

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_STEP = PI_Q60 / (ROM_DEPTH / 2);

  localparam logic [2:0] OP_ACC    = 3'd0;
  localparam logic [2:0] OP_ORIGIN = 3'd1;
  localparam logic [2:0] OP_TRANS  = 3'd2;
  localparam logic [2:0] OP_ROT    = 3'd3;
  localparam logic [2:0] OP_SCALE  = 3'd4;
  localparam logic [2:0] OP_ALPHA  = 3'd5;

  typedef logic signed [17:0] trig_t;
  typedef logic signed [23:0] coord_t;
  typedef logic signed [17:0] org_t;
  typedef logic signed [31:0] sum_t;
  typedef logic signed [41:0] acc_t;
  typedef trig_t trig_tbl_t [ROM_DEPTH];

  typedef struct packed {
    logic en;
    logic load;
    logic sub;
  } mac_ctl_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic signed [31:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] s;
    if (k == 0) return 32'sd0;
    if (k >= QUARTER_DEPTH) return 32'sd65536;
    x = (64'(k) * PI_STEP) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    s = $signed(x);
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * x2) >> 30, 64'(2 * n) * 64'(2 * n + 1));
      if ((n & 1) == 1) s = s - $signed(term);
      else s = s + $signed(term);
    end
    if (s < 0) s = 64'sd0;
    return 32'(s >>> 14);
  endfunction

  function automatic logic signed [31:0] full_sine(input int unsigned kin);
    int unsigned k;
    int unsigned q;
    k = kin & (ROM_DEPTH - 1);
    q = QUARTER_DEPTH;
    if (k <= q) return quarter_sine(k);
    if (k <= 2 * q) return quarter_sine(2 * q - k);
    if (k <= 3 * q) return -quarter_sine(k - 2 * q);
    return -quarter_sine(4 * q - k);
  endfunction

  function automatic trig_tbl_t build_trig(input int unsigned shift);
    trig_tbl_t t;
    for (int unsigned k = 0; k < ROM_DEPTH; k++) begin
      t[k] = 18'(full_sine(k + shift));
    end
    return t;
  endfunction

  localparam trig_tbl_t SIN_TBL = build_trig(0);
  localparam trig_tbl_t COS_TBL = build_trig(QUARTER_DEPTH);

endpackage

// File: sv/skeletal_vertex_transform_core.sv
// Skeletal vertex transform core: sequencer around a shared MAC and a serial divider.
// Rotation skips the MAC passes of any axis whose angle is zero; set origin runs one
// division per axis when vertices were accumulated, and loads the arguments directly otherwise.
// Throughput: one item at a time, set by the four MAC passes per rotation axis and
// the one-bit-per-cycle divider; in_stall is high while an item is in work.
// Reset (synchronous, rst_n low): origin, sums and count cleared, no result pending.
module skeletal_vertex_transform_core #(
  parameter int unsigned MAX_VERTS = slvt_pkg::MAX_GROUP_VERTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic signed [15:0] in_vert_x,
  input  logic signed [15:0] in_vert_y,
  input  logic signed [15:0] in_vert_z,
  input  logic signed [15:0] in_arg_a,
  input  logic signed [15:0] in_arg_b,
  input  logic signed [15:0] in_arg_c,
  input  logic [7:0]         in_alpha_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic [7:0]         out_alpha
);
  import slvt_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_ROT, ST_SCL, ST_FIN} state_t;

  state_t state_r;
  coord_t cx_r, cy_r, cz_r, newp_r;
  org_t   off_x_r, off_y_r, off_z_r;
  org_t   org_x_r, org_y_r, org_z_r;
  sum_t   sum_x_r, sum_y_r, sum_z_r;
  logic signed [15:0] arg_a_r, arg_b_r, arg_c_r;
  logic [15:0] cnt_r;
  logic [1:0]  axis_r, step_r, div_sel_r;
  logic [7:0]  alpha_r;
  logic        div_start_r;
  logic        out_valid_r;
  logic signed [15:0] out_x_r, out_y_r, out_z_r;
  logic [7:0]  out_alpha_r;

  logic        accept;
  logic [ROM_AW-1:0] ang;
  coord_t      p, q, rot_val, scl_val;
  trig_t       sn, cs, mul_a;
  coord_t      mul_b;
  mac_ctl_t    mac_ctl;
  acc_t        acc_sum, scl_adj;
  sum_t        div_dividend, div_q;
  logic        div_done;
  logic signed [19:0] alpha_sum;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_alpha = out_alpha_r;

  assign rot_val   = acc_sum[39:16];
  assign scl_adj   = acc_sum + ((acc_sum < 0) ? 42'sd127 : 42'sd0);
  assign scl_val   = scl_adj[30:7];
  assign alpha_sum = 20'($signed({1'b0, in_alpha_in})) + (20'(in_arg_a) <<< 3);

  always_comb begin
    ang = arg_b_r[ROM_AW-1:0];
    p   = cx_r;
    q   = cz_r;
    case (axis_r)
      2'd0: begin
        ang = arg_c_r[ROM_AW-1:0];
        p   = cx_r;
        q   = cy_r;
      end
      2'd1: begin
        ang = arg_a_r[ROM_AW-1:0];
        p   = cz_r;
        q   = cy_r;
      end
      default: ;
    endcase
    sn = SIN_TBL[ang];
    cs = COS_TBL[ang];
    mac_ctl = '0;
    mul_a   = cs;
    mul_b   = p;
    if (state_r == ST_ROT && ang != '0) begin
      mac_ctl.en = 1'b1;
      case (step_r)
        2'd0: begin
          mac_ctl.load = 1'b1;
        end
        2'd1: begin
          mul_a = sn;
          mul_b = q;
        end
        2'd2: begin
          mac_ctl.load = 1'b1;
          mul_b = q;
        end
        default: begin
          mac_ctl.sub = 1'b1;
          mul_a = sn;
        end
      endcase
    end else if (state_r == ST_SCL) begin
      mac_ctl.en   = 1'b1;
      mac_ctl.load = 1'b1;
      case (axis_r)
        2'd0: begin
          mul_a = 18'(arg_a_r);
          mul_b = cx_r;
        end
        2'd1: begin
          mul_a = 18'(arg_b_r);
          mul_b = cy_r;
        end
        default: begin
          mul_a = 18'(arg_c_r);
          mul_b = cz_r;
        end
      endcase
    end
  end

  always_comb begin
    case (div_sel_r)
      2'd0:    div_dividend = sum_x_r;
      2'd1:    div_dividend = sum_y_r;
      default: div_dividend = sum_z_r;
    endcase
  end

  slvt_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .acc_sum (acc_sum)
  );

  slvt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      org_x_r     <= '0;
      org_y_r     <= '0;
      org_z_r     <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      cnt_r       <= '0;
      axis_r      <= '0;
      step_r      <= '0;
      div_sel_r   <= '0;
    end else begin
      div_start_r <= (state_r == ST_IDLE && accept && in_op == OP_ORIGIN && cnt_r != '0) ||
                     (state_r == ST_DIV && div_done && div_sel_r != 2'd2);
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            arg_a_r <= in_arg_a;
            arg_b_r <= in_arg_b;
            arg_c_r <= in_arg_c;
            axis_r  <= '0;
            step_r  <= '0;
            case (in_op)
              OP_ACC: begin
                if (32'(cnt_r) < MAX_VERTS) begin
                  sum_x_r <= sum_x_r + 32'(in_vert_x);
                  sum_y_r <= sum_y_r + 32'(in_vert_y);
                  sum_z_r <= sum_z_r + 32'(in_vert_z);
                  cnt_r   <= cnt_r + 16'd1;
                end
              end
              OP_ORIGIN: begin
                if (cnt_r != '0) begin
                  state_r     <= ST_DIV;
                  div_sel_r   <= '0;
                end else begin
                  org_x_r <= 18'(in_arg_a);
                  org_y_r <= 18'(in_arg_b);
                  org_z_r <= 18'(in_arg_c);
                  sum_x_r <= '0;
                  sum_y_r <= '0;
                  sum_z_r <= '0;
                end
              end
              OP_TRANS: begin
                cx_r    <= 24'(in_vert_x);
                cy_r    <= 24'(in_vert_y);
                cz_r    <= 24'(in_vert_z);
                off_x_r <= 18'(in_arg_a);
                off_y_r <= 18'(in_arg_b);
                off_z_r <= 18'(in_arg_c);
                alpha_r <= '0;
                state_r <= ST_FIN;
              end
              OP_ROT, OP_SCALE: begin
                cx_r    <= 24'(in_vert_x) - 24'(org_x_r);
                cy_r    <= 24'(in_vert_y) - 24'(org_y_r);
                cz_r    <= 24'(in_vert_z) - 24'(org_z_r);
                off_x_r <= org_x_r;
                off_y_r <= org_y_r;
                off_z_r <= org_z_r;
                alpha_r <= '0;
                state_r <= (in_op == OP_ROT) ? ST_ROT : ST_SCL;
              end
              OP_ALPHA: begin
                cx_r    <= '0;
                cy_r    <= '0;
                cz_r    <= '0;
                off_x_r <= '0;
                off_y_r <= '0;
                off_z_r <= '0;
                if (alpha_sum < 0) begin
                  alpha_r <= 8'd0;
                end else if (alpha_sum > 20'sd255) begin
                  alpha_r <= 8'd255;
                end else begin
                  alpha_r <= alpha_sum[7:0];
                end
                state_r <= ST_FIN;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            case (div_sel_r)
              2'd0:    org_x_r <= 18'(arg_a_r) + 18'(div_q);
              2'd1:    org_y_r <= 18'(arg_b_r) + 18'(div_q);
              default: org_z_r <= 18'(arg_c_r) + 18'(div_q);
            endcase
            if (div_sel_r == 2'd2) begin
              sum_x_r <= '0;
              sum_y_r <= '0;
              sum_z_r <= '0;
              cnt_r   <= '0;
              state_r <= ST_IDLE;
            end else begin
              div_sel_r   <= div_sel_r + 2'd1;
            end
          end
        end
        ST_ROT: begin
          if (ang == '0 || step_r == 2'd3) begin
            if (ang != '0) begin
              case (axis_r)
                2'd0: begin
                  cx_r <= newp_r;
                  cy_r <= rot_val;
                end
                2'd1: begin
                  cz_r <= newp_r;
                  cy_r <= rot_val;
                end
                default: begin
                  cx_r <= newp_r;
                  cz_r <= rot_val;
                end
              endcase
            end
            step_r <= '0;
            if (axis_r == 2'd2) begin
              state_r <= ST_FIN;
            end else begin
              axis_r <= axis_r + 2'd1;
            end
          end else begin
            if (step_r == 2'd1) begin
              newp_r <= rot_val;
            end
            step_r <= step_r + 2'd1;
          end
        end
        ST_SCL: begin
          case (axis_r)
            2'd0:    cx_r <= scl_val;
            2'd1:    cy_r <= scl_val;
            default: cz_r <= scl_val;
          endcase
          if (axis_r == 2'd2) begin
            state_r <= ST_FIN;
          end else begin
            axis_r <= axis_r + 2'd1;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_x_r     <= cx_r[15:0] + off_x_r[15:0];
            out_y_r     <= cy_r[15:0] + off_y_r[15:0];
            out_z_r     <= cz_r[15:0] + off_z_r[15:0];
            out_alpha_r <= alpha_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/slvt_mac.sv
// Shared multiply-accumulate unit for rotation and scale products.
module slvt_mac (
  input  logic             clk,
  input  slvt_pkg::mac_ctl_t ctl,
  input  slvt_pkg::trig_t  mul_a,
  input  slvt_pkg::coord_t mul_b,
  output slvt_pkg::acc_t   acc_sum
);
  import slvt_pkg::*;

  logic signed [41:0] prod;
  acc_t acc_r;

  assign prod = mul_a * mul_b;

  always_comb begin
    if (ctl.load) begin
      acc_sum = prod;
    end else if (ctl.sub) begin
      acc_sum = acc_r - prod;
    end else begin
      acc_sum = acc_r + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_sum;
    end
  end

endmodule

// File: sv/slvt_div.sv
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
module slvt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  slvt_pkg::sum_t     dividend,
  input  logic [15:0]        divisor,
  output logic               done,
  output slvt_pkg::sum_t     quotient
);
  import slvt_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic        neg_r;
  logic [4:0]  cnt_r;
  logic [15:0] rem_r;
  logic [15:0] dvs_r;
  logic [31:0] quo_r;
  logic [16:0] trial;

  assign trial    = {rem_r, quo_r[31]};
  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
        neg_r  <= dividend[31];
        quo_r  <= dividend[31] ? 32'(-dividend) : 32'(dividend);
      end else if (busy_r) begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_r <= 16'(trial - {1'b0, dvs_r});
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= trial[15:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/slvt_chk.sv
// Port-level checker for the skeletal vertex transform core, bound into skeletal_vertex_transform_core.
module slvt_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         in_op,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [15:0] out_z,
  input logic [7:0]         out_alpha
);
  import slvt_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_TRANS || in_op == OP_ROT ||
    in_op == OP_SCALE || in_op == OP_ALPHA) |=> in_stall)
    else $error("input taken while transform in work");

  a_alpha_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alpha != 8'd0 |-> out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0)
    else $error("alpha result carries coordinates");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_alpha))
    else $error("stalled result changed");

endmodule

bind skeletal_vertex_transform_core slvt_chk u_slvt_chk (.*);

// File: dv/testbench.sv
// Testbench for skeletal_vertex_transform_core: random and directed vertex items checked against a built-in predictor.
`timescale 1ns / 100ps

module testbench;
  import slvt_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] vx, vy, vz, a, b, c;
    logic [7:0]         alpha;
  } vert_item_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic [7:0]         alpha;
  } vert_result_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int CALM_ITEMS     = 150;
  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;
  localparam longint unsigned PI_Q60_C = 64'h3243F6A8885A308D;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_op;
  logic signed [15:0] in_vert_x, in_vert_y, in_vert_z, in_arg_a, in_arg_b, in_arg_c;
  logic [7:0] in_alpha_in;
  logic out_valid, out_stall;
  logic signed [15:0] out_x, out_y, out_z;
  logic [7:0] out_alpha;

  vert_item_t   pending_items[$];
  vert_result_t expected_results[$];
  longint sine_q16[256];
  longint cosine_q16[256];
  longint pivot_x, pivot_y, pivot_z;
  longint group_sum_x, group_sum_y, group_sum_z;
  int unsigned group_count;
  int mismatches;
  int idle_cycles;
  int send_gap;
  int stall_burst;
  bit calm;

  skeletal_vertex_transform_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_vert_x(in_vert_x), .in_vert_y(in_vert_y), .in_vert_z(in_vert_z),
    .in_arg_a(in_arg_a), .in_arg_b(in_arg_b), .in_arg_c(in_arg_c),
    .in_alpha_in(in_alpha_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_alpha(out_alpha)
  );

  function automatic longint quarter_wave(int unsigned k);
    longint unsigned xr, x2, term;
    longint s;
    if (k == 0) return 0;
    if (k >= 64) return 65536;
    xr = (longint'(k) * (PI_Q60_C / 128)) >> 30;
    x2 = (xr * xr) >> 30;
    term = xr;
    s = longint'(xr);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    return s >>> 14;
  endfunction

  function automatic longint sine_at(int unsigned kin);
    int unsigned k;
    k = kin % 256;
    if (k <= 64) return quarter_wave(k);
    if (k <= 128) return quarter_wave(128 - k);
    if (k <= 192) return -quarter_wave(k - 128);
    return -quarter_wave(256 - k);
  endfunction

  task automatic turn_axis(input logic [7:0] angle, inout longint u, inout longint v);
    longint sn, cs, nu;
    if (angle != 0) begin
      sn = sine_q16[angle];
      cs = cosine_q16[angle];
      nu = (cs * u + sn * v) >>> 16;
      v = (cs * v - sn * u) >>> 16;
      u = nu;
    end
  endtask

  task automatic predict_transform(input vert_item_t it);
    vert_result_t r;
    longint x, y, z, al;
    r = '{x: 0, y: 0, z: 0, alpha: 0};
    case (it.op)
      OP_ACC: begin
        if (group_count < MAX_GROUP_VERTS) begin
          group_sum_x += it.vx;
          group_sum_y += it.vy;
          group_sum_z += it.vz;
          group_count++;
        end
      end
      OP_ORIGIN: begin
        pivot_x = it.a;
        pivot_y = it.b;
        pivot_z = it.c;
        if (group_count > 0) begin
          pivot_x += group_sum_x / longint'(group_count);
          pivot_y += group_sum_y / longint'(group_count);
          pivot_z += group_sum_z / longint'(group_count);
        end
        group_sum_x = 0;
        group_sum_y = 0;
        group_sum_z = 0;
        group_count = 0;
      end
      OP_TRANS: begin
        r.x = 16'(longint'(it.vx) + it.a);
        r.y = 16'(longint'(it.vy) + it.b);
        r.z = 16'(longint'(it.vz) + it.c);
        expected_results.push_back(r);
      end
      OP_ROT: begin
        x = it.vx - pivot_x;
        y = it.vy - pivot_y;
        z = it.vz - pivot_z;
        turn_axis(it.c[7:0], x, y);
        turn_axis(it.a[7:0], z, y);
        turn_axis(it.b[7:0], x, z);
        r.x = 16'(x + pivot_x);
        r.y = 16'(y + pivot_y);
        r.z = 16'(z + pivot_z);
        expected_results.push_back(r);
      end
      OP_SCALE: begin
        x = (longint'(it.a) * (it.vx - pivot_x)) / 128;
        y = (longint'(it.b) * (it.vy - pivot_y)) / 128;
        z = (longint'(it.c) * (it.vz - pivot_z)) / 128;
        r.x = 16'(x + pivot_x);
        r.y = 16'(y + pivot_y);
        r.z = 16'(z + pivot_z);
        expected_results.push_back(r);
      end
      OP_ALPHA: begin
        al = longint'(it.alpha) + longint'(it.a) * 8;
        if (al < 0) al = 0;
        if (al > 255) al = 255;
        r.alpha = 8'(al);
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(input logic [2:0] op, input logic signed [15:0] vx, vy, vz,
                            input logic signed [15:0] a, b, c, input logic [7:0] alpha);
    pending_items.push_back('{op: op, vx: vx, vy: vy, vz: vz, a: a, b: b, c: c,
                              alpha: alpha});
  endtask

  task automatic queue_random(input logic [2:0] op);
    logic signed [15:0] a, b, c;
    a = 16'($urandom);
    b = 16'($urandom);
    c = 16'($urandom);
    if (op == OP_ROT) begin
      if ($urandom_range(0, 3) == 0) a[7:0] = 8'd0;
      if ($urandom_range(0, 3) == 0) b[7:0] = 8'd0;
      if ($urandom_range(0, 3) == 0) c[7:0] = 8'd0;
    end
    if (op == OP_ALPHA && $urandom_range(0, 1) == 1) a = 16'($signed(5'($urandom)));
    if (op == OP_SCALE && $urandom_range(0, 1) == 1) begin
      a = 16'($urandom_range(0, 512)) - 16'sd256;
      b = 16'($urandom_range(0, 512)) - 16'sd256;
      c = 16'($urandom_range(0, 512)) - 16'sd256;
    end
    queue_item(op, 16'($urandom), 16'($urandom), 16'($urandom), a, b, c, 8'($urandom));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < 256; k++) begin
      sine_q16[k] = sine_at(k);
      cosine_q16[k] = sine_at(k + 64);
    end
    pivot_x = 0; pivot_y = 0; pivot_z = 0;
    group_sum_x = 0; group_sum_y = 0; group_sum_z = 0;
    group_count = 0;

    queue_item(OP_TRANS, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sh7FFF, 16'sh8000, 16'shFFFF, 8'd0);
    queue_item(OP_TRANS, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh8000, 16'sh7FFF, 16'sd1, 8'hFF);
    queue_item(OP_ALPHA, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 8'hFF);
    queue_item(OP_ALPHA, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 8'hFF);
    queue_item(OP_ALPHA, 16'sd0, 16'sd0, 16'sd0, -16'sd3, 16'sd0, 16'sd0, 8'd30);
    queue_item(OP_ALPHA, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd77);
    queue_item(OP_NOP6, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 8'd7);
    queue_item(OP_NOP7, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 8'hFF);
    queue_item(OP_ORIGIN, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sd100, 8'd0);
    queue_item(OP_ROT, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd64, 16'sd128, 16'sd192, 8'd0);
    queue_item(OP_SCALE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 8'd0);
    queue_item(OP_ACC, -16'sd5, 16'sd7, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 8'd0);
    queue_item(OP_ACC, -16'sd2, 16'sd4, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 8'd0);
    queue_item(OP_ACC, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 8'd0);
    queue_item(OP_ORIGIN, 16'sd0, 16'sd0, 16'sd0, 16'sd10, -16'sd10, 16'sd0, 8'd0);
    queue_item(OP_ROT, 16'sd100, 16'sd200, 16'sd300, 16'sd0, 16'sd0, 16'sd0, 8'd0);
    queue_item(OP_ROT, 16'sd100, -16'sd200, 16'sd300, 16'sh0100, 16'sh7F40, 16'sd33, 8'd0);
    queue_item(OP_ROT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd255, 16'sd1, 16'sd127, 8'd0);
    queue_item(OP_SCALE, -16'sd300, 16'sd301, -16'sd1, 16'sd128, 16'sd1, -16'sd1, 8'd0);
    queue_item(OP_SCALE, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd256, -16'sd128, 8'd0);

    while (pending_items.size() < 1450) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_random(3'($urandom_range(0, 7)));
      end else begin
        repeat ($urandom_range(0, 6)) queue_random(OP_ACC);
        queue_random(OP_ORIGIN);
        repeat ($urandom_range(1, 8))
          queue_random(3'($urandom_range(OP_TRANS, OP_ALPHA)));
      end
    end

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_op       <= '0;
      in_vert_x   <= '0;
      in_vert_y   <= '0;
      in_vert_z   <= '0;
      in_arg_a    <= '0;
      in_arg_b    <= '0;
      in_arg_c    <= '0;
      in_alpha_in <= '0;
      send_gap    <= 0;
      calm        <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      calm <= pending_items.size() < CALM_ITEMS;
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        vert_item_t it;
        it = pending_items.pop_front();
        in_valid    <= 1'b1;
        in_op       <= it.op;
        in_vert_x   <= it.vx;
        in_vert_y   <= it.vy;
        in_vert_z   <= it.vz;
        in_arg_a    <= it.a;
        in_arg_b    <= it.b;
        in_arg_c    <= it.c;
        in_alpha_in <= it.alpha;
        if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_burst <= 0;
      mismatches  <= 0;
      idle_cycles <= 0;
    end else begin
      if (stall_burst > 0) begin
        out_stall   <= 1'b1;
        stall_burst <= stall_burst - 1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) stall_burst <= $urandom_range(1, 16);
      end

      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected transfer: x=%0d y=%0d z=%0d alpha=%0d",
                     out_x, out_y, out_z, out_alpha);
          mismatches <= mismatches + 1;
        end else begin
          vert_result_t e;
          e = expected_results.pop_front();
          if (out_x !== e.x || out_y !== e.y || out_z !== e.z || out_alpha !== e.alpha) begin
            if (mismatches < 10)
              $display("mismatch: exp x=%0d y=%0d z=%0d alpha=%0d, got x=%0d y=%0d z=%0d alpha=%0d",
                       e.x, e.y, e.z, e.alpha, out_x, out_y, out_z, out_alpha);
            mismatches <= mismatches + 1;
          end
        end
      end

      if (in_valid && !in_stall) begin
        predict_transform('{op: in_op, vx: in_vert_x, vy: in_vert_y, vz: in_vert_z,
                            a: in_arg_a, b: in_arg_b, c: in_arg_c, alpha: in_alpha_in});
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
